// ----- hdl/gf2mpv_pkg.sv -----
// Shared constants and types for the GF(2) matrix product verifier.
// Holds field widths, opcodes and the controller to datapath command/status.
// No dependencies.
package gf2mpv_pkg;

   localparam int N          = 64;
   localparam int ROW_W      = 64;
   localparam int ROW_IDX_W  = $clog2(N);
   localparam int SIZE_W     = 7;
   localparam int OPCODE_W   = 3;

   localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(N);

   localparam logic [OPCODE_W-1:0] OP_LOAD_A = 3'd0;
   localparam logic [OPCODE_W-1:0] OP_LOAD_B = 3'd1;
   localparam logic [OPCODE_W-1:0] OP_LOAD_C = 3'd2;
   localparam logic [OPCODE_W-1:0] OP_TRIAL  = 3'd3;
   localparam logic [OPCODE_W-1:0] OP_CLEAR  = 3'd4;

   typedef struct packed {
      logic                 take;
      logic                 rd_en;
      logic                 rd_pass_a;
      logic [ROW_IDX_W-1:0] rd_addr;
      logic                 post_trial;
   } gf2mpv_cmd_type;

   typedef struct packed {
      logic [ROW_IDX_W-1:0] last_row;
   } gf2mpv_status_type;

endpackage

// ----- hdl/gf2mpv_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
// Used for the three matrix row stores. No dependencies.
module gf2mpv_ram #(
   parameter int WIDTH      = 64,
   parameter int DEPTH      = 64,
   parameter int ADDR_WIDTH = $clog2(DEPTH)
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [ADDR_WIDTH-1:0] wr_addr,
   input  logic [WIDTH-1:0]      wr_data,
   input  logic [ADDR_WIDTH-1:0] rd_addr,
   output logic [WIDTH-1:0]      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/gf2mpv_datapath.sv -----
// Datapath of the GF(2) matrix product verifier: row stores, size register,
// trial vectors, mismatch accumulation, verdict and result payload.
// Depends on gf2mpv_pkg and gf2mpv_ram.
module gf2mpv_datapath
   import gf2mpv_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  gf2mpv_cmd_type          cmd,
   output gf2mpv_status_type       status,
   input  logic [OPCODE_W-1:0]     req_opcode,
   input  logic [ROW_IDX_W-1:0]    req_row_index,
   input  logic [ROW_W-1:0]        req_bits,
   input  logic                    csr_write_enable,
   input  logic [SIZE_W-1:0]       csr_write_data,
   output logic                    rsp_mismatch_now,
   output logic                    rsp_verdict_ok
);

   logic [SIZE_W-1:0]    size_ff;
   logic [SIZE_W-1:0]    n_eff;
   logic [ROW_W-1:0]     mask;
   logic [ROW_W-1:0]     x_ff;
   logic [ROW_W-1:0]     bx_ff;
   logic [ROW_W-1:0]     cx_ff;
   logic                 mism_ff;
   logic                 verdict_ff;
   logic                 verdict_in;
   logic                 rd_valid_ff;
   logic                 rd_pass_a_ff;
   logic [ROW_IDX_W-1:0] rd_row_ff;
   logic                 rsp_mismatch_now_ff;
   logic                 rsp_verdict_ok_ff;
   logic [ROW_W-1:0]     a_rd;
   logic [ROW_W-1:0]     b_rd;
   logic [ROW_W-1:0]     c_rd;
   logic                 we_a;
   logic                 we_b;
   logic                 we_c;
   logic                 abx_bit;

   always_comb begin
      if (size_ff == '0) begin
         n_eff = SIZE_W'(1);
      end else if (size_ff > SIZE_W'(N)) begin
         n_eff = SIZE_W'(N);
      end else begin
         n_eff = size_ff;
      end
      for (int i = 0; i < ROW_W; i++) begin
         mask[i] = (SIZE_W'(i) < n_eff);
      end
   end

   assign status.last_row = ROW_IDX_W'(n_eff - SIZE_W'(1));

   assign we_a = cmd.take && (req_opcode == OP_LOAD_A);
   assign we_b = cmd.take && (req_opcode == OP_LOAD_B);
   assign we_c = cmd.take && (req_opcode == OP_LOAD_C);

   gf2mpv_ram #(.WIDTH(ROW_W), .DEPTH(N)) u_ram_a (
      .clock   (clock),
      .wr_en   (we_a),
      .wr_addr (req_row_index),
      .wr_data (req_bits),
      .rd_addr (cmd.rd_addr),
      .rd_data (a_rd)
   );

   gf2mpv_ram #(.WIDTH(ROW_W), .DEPTH(N)) u_ram_b (
      .clock   (clock),
      .wr_en   (we_b),
      .wr_addr (req_row_index),
      .wr_data (req_bits),
      .rd_addr (cmd.rd_addr),
      .rd_data (b_rd)
   );

   gf2mpv_ram #(.WIDTH(ROW_W), .DEPTH(N)) u_ram_c (
      .clock   (clock),
      .wr_en   (we_c),
      .wr_addr (req_row_index),
      .wr_data (req_bits),
      .rd_addr (cmd.rd_addr),
      .rd_data (c_rd)
   );

   // Bits of Bx at rows beyond n may be stale from an earlier trial and are masked.
   assign abx_bit = ^(a_rd & bx_ff & mask);
   assign verdict_in = verdict_ff & ~mism_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff     <= SIZE_RESET;
         verdict_ff  <= 1'b1;
         rd_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            size_ff <= csr_write_data;
         end
         rd_valid_ff <= cmd.rd_en;
         if (cmd.take && (req_opcode == OP_CLEAR)) begin
            verdict_ff <= 1'b1;
         end else if (cmd.post_trial) begin
            verdict_ff <= verdict_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_pass_a_ff <= cmd.rd_pass_a;
      rd_row_ff    <= cmd.rd_addr;
      if (cmd.take) begin
         case (req_opcode)
            OP_TRIAL: begin
               x_ff    <= req_bits & mask;
               mism_ff <= 1'b0;
            end
            OP_CLEAR: begin
               rsp_mismatch_now_ff <= 1'b0;
               rsp_verdict_ok_ff   <= 1'b1;
            end
            default: begin
               rsp_mismatch_now_ff <= 1'b0;
               rsp_verdict_ok_ff   <= verdict_ff;
            end
         endcase
      end
      if (rd_valid_ff && !rd_pass_a_ff) begin
         bx_ff[rd_row_ff] <= ^(b_rd & x_ff);
         cx_ff[rd_row_ff] <= ^(c_rd & x_ff);
      end
      if (rd_valid_ff && rd_pass_a_ff) begin
         mism_ff <= mism_ff | (abx_bit ^ cx_ff[rd_row_ff]);
      end
      if (cmd.post_trial) begin
         rsp_mismatch_now_ff <= mism_ff;
         rsp_verdict_ok_ff   <= verdict_in;
      end
   end

   assign rsp_mismatch_now = rsp_mismatch_now_ff;
   assign rsp_verdict_ok   = rsp_verdict_ok_ff;

endmodule

// ----- hdl/gf2mpv_ctrl.sv -----
// Controller of the GF(2) matrix product verifier: handshakes, the row
// sweep counter for the two trial passes and the result valid flag.
// Depends on gf2mpv_pkg.
module gf2mpv_ctrl
   import gf2mpv_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic [OPCODE_W-1:0] req_opcode,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output gf2mpv_cmd_type      cmd,
   input  gf2mpv_status_type   status
);

   typedef enum logic [4:0] {
      ST_IDLE    = 5'b00001,
      ST_PASS_BC = 5'b00010,
      ST_PASS_A  = 5'b00100,
      ST_DRAIN   = 5'b01000,
      ST_FINISH  = 5'b10000
   } state_type;

   state_type            state_ff;
   state_type            state_in;
   logic [ROW_IDX_W-1:0] addr_ff;
   logic [ROW_IDX_W-1:0] addr_in;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   logic                 out_free;
   logic                 take;
   logic                 at_last;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !((state_ff == ST_IDLE) && out_free);
   assign take      = req_valid && !req_stall;
   assign at_last   = (addr_ff == status.last_row);

   always_comb begin
      state_in       = state_ff;
      addr_in        = addr_ff;
      cmd.take       = take;
      cmd.rd_en      = 1'b0;
      cmd.rd_pass_a  = 1'b0;
      cmd.rd_addr    = addr_ff;
      cmd.post_trial = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            addr_in = '0;
            if (take && (req_opcode == OP_TRIAL)) begin
               state_in = ST_PASS_BC;
            end
         end
         ST_PASS_BC: begin
            cmd.rd_en = 1'b1;
            if (at_last) begin
               addr_in  = '0;
               state_in = ST_PASS_A;
            end else begin
               addr_in = addr_ff + ROW_IDX_W'(1);
            end
         end
         ST_PASS_A: begin
            cmd.rd_en     = 1'b1;
            cmd.rd_pass_a = 1'b1;
            if (at_last) begin
               state_in = ST_DRAIN;
            end else begin
               addr_in = addr_ff + ROW_IDX_W'(1);
            end
         end
         ST_DRAIN: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) begin
               cmd.post_trial = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if ((take && (req_opcode != OP_TRIAL)) || cmd.post_trial) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         addr_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- hdl/gf2_matrix_product_verifier_core.sv -----
// Top level of the GF(2) matrix product verifier (Freivalds check).
// Joins the controller and the datapath. Depends on gf2mpv_pkg,
// gf2mpv_ctrl and gf2mpv_datapath.
//
// Usage: each item on the req_ channel is an opcode, a row index and 64 bits.
// Loads write one row of A, B or C; a clear sets the verdict true; a trial
// checks A(Bx) against Cx for the vector x in req_bits. Every item gives
// exactly one item on the rsp_ channel with mismatch_now and verdict_ok.
// Loads, clears and unknown opcodes answer in the cycle after acceptance.
// A trial sweeps the n rows in use twice, then drains and finishes: one
// reads B and C together a row per cycle, a second reads A a row per
// cycle, set by the single read port of each row store. One item is in
// work at a time. csr_write_data sets n; the user is to write it only
// while the block is idle, which the block itself does not enforce. Reset
// makes the verdict true and n equal to 64; the row stores hold nothing
// until written. While rsp_stall holds a waiting result, a new item is
// accepted only once that result leaves, and a finished trial waits in place.
module gf2_matrix_product_verifier_core
   import gf2mpv_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [OPCODE_W-1:0]  req_opcode,
   input  logic [ROW_IDX_W-1:0] req_row_index,
   input  logic [ROW_W-1:0]     req_bits,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_mismatch_now,
   output logic                 rsp_verdict_ok,
   input  logic                 csr_write_enable,
   input  logic [SIZE_W-1:0]    csr_write_data
);

   gf2mpv_cmd_type    cmd;
   gf2mpv_status_type status;

   gf2mpv_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_opcode (req_opcode),
      .req_stall  (req_stall),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .cmd        (cmd),
      .status     (status)
   );

   gf2mpv_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_opcode       (req_opcode),
      .req_row_index    (req_row_index),
      .req_bits         (req_bits),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp_mismatch_now (rsp_mismatch_now),
      .rsp_verdict_ok   (rsp_verdict_ok)
   );

endmodule

// ----- hdl/gf2mpv_checker.sv -----
// Port-level checker for the GF(2) matrix product verifier, bound to the top.
// Depends on gf2mpv_pkg and gf2_matrix_product_verifier_core.
module gf2mpv_checker
   import gf2mpv_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_stall,
   input logic [OPCODE_W-1:0]  req_opcode,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input logic                 rsp_mismatch_now,
   input logic                 rsp_verdict_ok
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_mismatch_now)
                                 && $stable(rsp_verdict_ok))
      else $error("Stalled result item changed or vanished.");

   a_quick_answer: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_opcode != OP_TRIAL |=> rsp_valid && !rsp_mismatch_now)
      else $error("Non-trial item did not answer next cycle without mismatch.");

   a_clear_sets: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_opcode == OP_CLEAR |=> rsp_verdict_ok)
      else $error("Clear item did not report a true verdict.");

   a_mismatch_verdict: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_mismatch_now |-> !rsp_verdict_ok)
      else $error("Mismatching trial reported a true verdict.");

   a_trial_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_opcode == OP_TRIAL |=> req_stall && !rsp_valid)
      else $error("Trial item did not hold off the input channel.");

endmodule

bind gf2_matrix_product_verifier_core gf2mpv_checker u_checker (.*);

// ----- dv/gf2mpv_checker.sv -----
// Checker for the GF(2) matrix product verifier: watches the req_, rsp_ and csr_ ports,
// keeps its own row stores, size register and verdict, and compares every result item.
// Depends on gf2mpv_pkg.
module gf2mpv_tb_checker
   import gf2mpv_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  logic [OPCODE_W-1:0]  req_opcode,
   input  logic [ROW_IDX_W-1:0] req_row_index,
   input  logic [ROW_W-1:0]     req_bits,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  logic                 rsp_mismatch_now,
   input  logic                 rsp_verdict_ok,
   input  logic                 csr_write_enable,
   input  logic [SIZE_W-1:0]    csr_write_data,
   output int                   error_count,
   output int                   outcomes_pending
);

   localparam int ROW_LIMIT  = (N < ROW_W) ? N : ROW_W;
   localparam int MAX_REPORT = 10;

   typedef struct packed {
      logic mismatch_now;
      logic verdict_ok;
   } trial_outcome_type;

   logic [ROW_W-1:0]  row_store [4][N];
   logic              verdict_state;
   logic [SIZE_W-1:0] size_reg;
   trial_outcome_type expected_outcomes [$];
   trial_outcome_type got;
   trial_outcome_type want;
   int                eff_n;
   logic [ROW_W-1:0]  col_mask;
   logic [ROW_W-1:0]  x_vec;
   logic [ROW_W-1:0]  bx;
   logic [ROW_W-1:0]  abx;
   logic [ROW_W-1:0]  cx;

   always @(posedge clock) begin
      if (reset) begin
         verdict_state = 1'b1;
         size_reg = SIZE_RESET;
         error_count = 0;
         expected_outcomes.delete();
         for (int m = 0; m < 4; m++) begin
            for (int i = 0; i < N; i++) begin
               row_store[m][i] = '0;
            end
         end
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got.mismatch_now = rsp_mismatch_now;
            got.verdict_ok = rsp_verdict_ok;
            if (expected_outcomes.size() == 0) begin
               error_count++;
               if (error_count <= MAX_REPORT) begin
                  $display("unexpected result item: mismatch_now=%0b verdict_ok=%0b",
                           got.mismatch_now, got.verdict_ok);
               end
            end else begin
               want = expected_outcomes.pop_front();
               if (got.mismatch_now !== want.mismatch_now ||
                   got.verdict_ok !== want.verdict_ok) begin
                  error_count++;
                  if (error_count <= MAX_REPORT) begin
                     $display("result mismatch: expected mismatch_now=%0b verdict_ok=%0b, %s",
                              want.mismatch_now, want.verdict_ok,
                              $sformatf("got mismatch_now=%0b verdict_ok=%0b",
                                        got.mismatch_now, got.verdict_ok));
                  end
               end
            end
         end
         if (req_valid && !req_stall) begin
            want.mismatch_now = 1'b0;
            case (req_opcode)
               OP_LOAD_A, OP_LOAD_B, OP_LOAD_C: begin
                  row_store[req_opcode[1:0]][req_row_index] = req_bits;
               end
               OP_TRIAL: begin
                  eff_n = size_reg;
                  if (eff_n < 1) eff_n = 1;
                  if (eff_n > ROW_LIMIT) eff_n = ROW_LIMIT;
                  col_mask = (eff_n >= ROW_W) ? '1 : ((ROW_W'(1) << eff_n) - ROW_W'(1));
                  x_vec = req_bits & col_mask;
                  bx = '0;
                  abx = '0;
                  cx = '0;
                  for (int i = 0; i < eff_n; i++) begin
                     bx[i] = ^(row_store[OP_LOAD_B[1:0]][i] & x_vec);
                     cx[i] = ^(row_store[OP_LOAD_C[1:0]][i] & x_vec);
                  end
                  for (int i = 0; i < eff_n; i++) begin
                     abx[i] = ^(row_store[OP_LOAD_A[1:0]][i] & bx);
                  end
                  if (((abx ^ cx) & col_mask) != '0) begin
                     want.mismatch_now = 1'b1;
                     verdict_state = 1'b0;
                  end
               end
               OP_CLEAR: begin
                  verdict_state = 1'b1;
               end
               default: begin
               end
            endcase
            want.verdict_ok = verdict_state;
            expected_outcomes.push_back(want);
         end
         if (csr_write_enable) begin
            size_reg = csr_write_data;
         end
      end
      outcomes_pending = expected_outcomes.size();
   end

endmodule

// ----- dv/tb_top.sv -----
// Testbench top for gf2_matrix_product_verifier_core: clock, reset, size register writes,
// directed and random row loads, trials and clears, random stalls, and the final verdict.
// Depends on gf2mpv_pkg, gf2_matrix_product_verifier_core and gf2mpv_tb_checker.
module tb_top;
   import gf2mpv_pkg::*;

   localparam int ROW_LIMIT   = (N < ROW_W) ? N : ROW_W;
   localparam int ITEM_TARGET = 1200;
   localparam int CYCLE_LIMIT = 800000;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic [OPCODE_W-1:0]  req_opcode;
   logic [ROW_IDX_W-1:0] req_row_index;
   logic [ROW_W-1:0]     req_bits;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic                 rsp_mismatch_now;
   logic                 rsp_verdict_ok;
   logic                 csr_write_enable;
   logic [SIZE_W-1:0]    csr_write_data;
   int                   error_count;
   int                   outcomes_pending;

   logic [ROW_W-1:0]     a_image [N];
   logic [ROW_W-1:0]     b_image [N];
   logic [N-1:0]         a_written;
   logic [N-1:0]         b_written;
   logic [N-1:0]         c_written;
   logic                 steady_flow;
   int                   items_sent;
   int                   cycle_count = 0;

   gf2_matrix_product_verifier_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_opcode       (req_opcode),
      .req_row_index    (req_row_index),
      .req_bits         (req_bits),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_mismatch_now (rsp_mismatch_now),
      .rsp_verdict_ok   (rsp_verdict_ok),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   gf2mpv_tb_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_opcode       (req_opcode),
      .req_row_index    (req_row_index),
      .req_bits         (req_bits),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_mismatch_now (rsp_mismatch_now),
      .rsp_verdict_ok   (rsp_verdict_ok),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .error_count      (error_count),
      .outcomes_pending (outcomes_pending)
   );

   always #10 clock = ~clock;

   always @(negedge clock) begin
      rsp_stall <= steady_flow ? 1'b0 : ($urandom_range(99) < 21);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("** gf2_matrix_product_verifier_core: FAILED **");
         $finish;
      end
   end

   function automatic logic [ROW_W-1:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [ROW_W-1:0] low_mask(input int n);
      return (n >= ROW_W) ? '1 : ((ROW_W'(1) << n) - ROW_W'(1));
   endfunction

   function automatic int effective_size(input int value);
      if (value < 1) return 1;
      if (value > ROW_LIMIT) return ROW_LIMIT;
      return value;
   endfunction

   function automatic bit trial_allowed(input int n);
      return ((ROW_W'(a_written & b_written & c_written) & low_mask(n)) == low_mask(n));
   endfunction

   // Row i of A times B over GF(2), restricted to the first n columns.
   function automatic logic [ROW_W-1:0] product_row(input int i, input int n);
      logic [ROW_W-1:0] acc;
      acc = '0;
      for (int k = 0; k < n; k++) begin
         if (a_image[i][k]) acc ^= b_image[k];
      end
      return acc & low_mask(n);
   endfunction

   task automatic send_item(input logic [OPCODE_W-1:0] op, input int row,
                            input logic [ROW_W-1:0] bits);
      if (!steady_flow && $urandom_range(99) < 21) begin
         req_valid <= 1'b0;
         do @(negedge clock); while (!steady_flow && $urandom_range(99) < 21);
      end
      req_valid <= 1'b1;
      req_opcode <= op;
      req_row_index <= ROW_IDX_W'(row);
      req_bits <= bits;
      case (op)
         OP_LOAD_A: begin
            a_image[row] = bits;
            a_written[row] = 1'b1;
         end
         OP_LOAD_B: begin
            b_image[row] = bits;
            b_written[row] = 1'b1;
         end
         OP_LOAD_C: begin
            c_written[row] = 1'b1;
         end
         default: begin
         end
      endcase
      if (op <= OP_CLEAR) items_sent++;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(negedge clock); while (outcomes_pending != 0);
   endtask

   task automatic write_size(input int value);
      csr_write_enable <= 1'b1;
      csr_write_data <= SIZE_W'(value);
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   initial begin
      int                  phase;
      int                  size_value;
      int                  eff;
      int                  seqs;
      int                  op_code;
      int                  bad_row;
      int                  bad_col;
      logic [ROW_W-1:0]    c_row;
      logic [OPCODE_W-1:0] noise_op;

      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_opcode = '0;
      req_row_index = '0;
      req_bits = '0;
      csr_write_enable = 1'b0;
      csr_write_data = '0;
      steady_flow = 1'b0;
      items_sent = 0;
      a_written = '0;
      b_written = '0;
      c_written = '0;
      for (int i = 0; i < N; i++) begin
         a_image[i] = '0;
         b_image[i] = '0;
      end
      repeat (2) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part on a 2 by 2 product, with junk in the ignored columns and rows.
      write_size(2);
      send_item(OP_LOAD_A, 0, '1);
      send_item(OP_LOAD_A, 1, rand64());
      send_item(OP_LOAD_B, 0, '0);
      send_item(OP_LOAD_B, 1, '1);
      send_item(OP_LOAD_C, 0, product_row(0, 2) | ~low_mask(2));
      send_item(OP_LOAD_C, 1, product_row(1, 2));
      send_item(OP_LOAD_A, N - 1, rand64());
      send_item(OP_TRIAL, 0, '1);
      send_item(OP_TRIAL, N - 1, '0);
      send_item(OP_TRIAL, 5, ~low_mask(2));
      send_item(OP_LOAD_C, 0, product_row(0, 2) ^ ROW_W'(1));
      send_item(OP_TRIAL, 0, '1);
      send_item(OP_TRIAL, 0, '0);
      for (op_code = OP_CLEAR + 1; op_code < 2 ** OPCODE_W; op_code++) begin
         send_item(OPCODE_W'(op_code), $urandom_range(N - 1), rand64());
      end
      send_item(OP_CLEAR, 0, rand64());
      send_item(OP_TRIAL, 0, '1);
      send_item(OP_LOAD_C, 0, product_row(0, 2));
      send_item(OP_CLEAR, N - 1, '1);
      send_item(OP_TRIAL, 0, '1);
      drain();
      write_size(0);
      send_item(OP_TRIAL, 0, '1);

      // Random phases, each under one size setting.
      phase = 0;
      while (items_sent < ITEM_TARGET) begin
         case (phase)
            0: size_value = 64;
            1: size_value = 2 ** SIZE_W - 1;
            2: size_value = 1;
            default: size_value = ($urandom_range(9) == 0) ? 0 : $urandom_range(2, 12);
         endcase
         drain();
         steady_flow = (phase == 4 || phase == 5);
         write_size(size_value);
         eff = effective_size(size_value);
         seqs = (eff > 16) ? 1 : $urandom_range(3, 5);
         repeat (seqs) begin
            if (trial_allowed(eff) && $urandom_range(4) == 0) begin
               repeat ($urandom_range(3, 8)) begin
                  noise_op = OPCODE_W'($urandom_range(2 ** OPCODE_W - 1));
                  send_item(noise_op, $urandom_range(N - 1), rand64());
               end
            end else begin
               bad_row = ($urandom_range(2) == 0) ? $urandom_range(eff - 1) : -1;
               bad_col = $urandom_range(eff - 1);
               for (int i = 0; i < eff; i++) send_item(OP_LOAD_A, i, rand64());
               for (int i = 0; i < eff; i++) send_item(OP_LOAD_B, i, rand64());
               for (int i = 0; i < eff; i++) begin
                  c_row = product_row(i, eff) | (rand64() & ~low_mask(eff));
                  if (i == bad_row) c_row[bad_col] = ~c_row[bad_col];
                  send_item(OP_LOAD_C, i, c_row);
               end
               repeat ($urandom_range(2, 6)) begin
                  send_item(OP_TRIAL, $urandom_range(N - 1), rand64());
               end
               if ($urandom_range(1) == 0) send_item(OP_CLEAR, $urandom_range(N - 1), rand64());
            end
            if ($urandom_range(5) == 0) drain();
         end
         phase++;
      end

      drain();
      repeat (2 * ROW_W + 8) @(negedge clock);
      if (error_count == 0 && outcomes_pending == 0) begin
         $display("** gf2_matrix_product_verifier_core: PASSED **");
      end else begin
         $display("** gf2_matrix_product_verifier_core: FAILED **");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
hdl/gf2mpv_pkg.sv
hdl/gf2mpv_ram.sv
hdl/gf2mpv_datapath.sv
hdl/gf2mpv_ctrl.sv
hdl/gf2_matrix_product_verifier_core.sv
hdl/gf2mpv_checker.sv
dv/gf2mpv_checker.sv
dv/tb_top.sv
